>>> design/strongly_connected_components_macros.svh
// Assertion macros used by the one file that checks its own logic.
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc: next-cycle check failed");

`endif

>>> design/scc_pkg.sv
`default_nettype none
package scc_pkg;

    // Fixed field widths of the ports.
    localparam int NODE_W        = 6;
    localparam int CNT_W         = 7;
    localparam int ROW_W         = 64;
    localparam int DEF_MAX_NODES = 64;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FNEXT,
        S_FRD,
        S_FSCAN,
        S_FPOP,
        S_PPOP,
        S_PV,
        S_PRD,
        S_PCHK,
        S_PSPOP,
        S_ORD,
        S_OEMIT
    } t_state;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SKIP,
        OP_FSTART,
        OP_FREAD,
        OP_FSTEP,
        OP_FPUSH,
        OP_FFIN,
        OP_FPOP,
        OP_PPOP,
        OP_PSTART,
        OP_PREAD,
        OP_PCHK,
        OP_PSPOP_RD,
        OP_PSPOP,
        OP_OINIT,
        OP_ORD,
        OP_OEMIT
    } t_op;

    // Status returned by the datapath.
    typedef struct packed {
        logic k_end;
        logic hit;
        logic sp_zero;
        logic fsp_zero;
        logic s_end;
        logic s_seen;
        logic i_end;
        logic v_labelled;
        logic last_i;
    } t_status;

endpackage
`default_nettype wire

>>> design/strongly_connected_components.sv
// Channel    Direction  Handshake        Payload
// row in     input      start / busy     i_row_index, i_row_bits, i_last_row
// config     input      i_cfg_we         i_cfg_data (node count)
// labels     output     o_valid strobe   o_node_id, o_component, o_last_node
//
// A row is taken on start while idle. A final row starts the run: pass one
// scans one bit a cycle between row reads and pass two one row at a time,
// both through the one-port forward row memory. Labels then leave one by
// one, each read first through the label memory port.
// Reset is synchronous and clears all control state; busy is high all run.
// The receiver cannot stall, so each label is shown for one cycle only.
`default_nettype none
`include "strongly_connected_components_macros.svh"
module strongly_connected_components
    import scc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [NODE_W-1:0] i_row_index,
    input  wire logic [ROW_W-1:0]  i_row_bits,
    input  wire logic              i_last_row,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output logic [NODE_W-1:0]      o_node_id,
    output logic [CNT_W-1:0]       o_component,
    output logic                   o_last_node
);

    t_op     op;
    t_status status;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_row (i_last_row),
        .i_status   (status),
        .o_op       (op),
        .o_busy     (busy)
    );

    scc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_last_row  (i_last_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_node_id   (o_node_id),
        .o_component (o_component),
        .o_last_node (o_last_node)
    );

    // A row that is not final never starts a run.
    `SCC_ASSERT_NXT(a_plain_row, i_clk, i_rst_n, start && !busy && !i_last_row, !busy)
    // Labels other than the final one leave while the block is still busy.
    `SCC_ASSERT_IMP(a_label_busy, i_clk, i_rst_n, o_valid && !o_last_node, busy)
    // Each label but the final one is followed by a gap, then the next label.
    `SCC_ASSERT_NXT(a_label_gap, i_clk, i_rst_n, o_valid && !o_last_node, !o_valid ##1 o_valid)
    // A label never carries component zero.
    `SCC_ASSERT_IMP(a_label_nonzero, i_clk, i_rst_n, o_valid, o_component != '0)

endmodule
`default_nettype wire

>>> design/scc_ctrl.sv
`default_nettype none
module scc_ctrl
    import scc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_last_row,
    input  wire t_status i_status,
    output t_op          o_op,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and the operation for the datapath.
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op = OP_LOAD;
                    if (i_last_row) begin
                        n_state = S_FNEXT;
                    end
                end
            end
            S_FNEXT: begin
                if (i_status.s_end) begin
                    n_state = S_PPOP;
                end else if (i_status.s_seen) begin
                    o_op = OP_SKIP;
                end else begin
                    o_op    = OP_FSTART;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                o_op    = OP_FREAD;
                n_state = S_FSCAN;
            end
            S_FSCAN: begin
                if (i_status.k_end) begin
                    o_op    = OP_FFIN;
                    n_state = i_status.sp_zero ? S_FNEXT : S_FPOP;
                end else if (i_status.hit) begin
                    o_op    = OP_FPUSH;
                    n_state = S_FRD;
                end else begin
                    o_op = OP_FSTEP;
                end
            end
            S_FPOP: begin
                o_op    = OP_FPOP;
                n_state = S_FRD;
            end
            S_PPOP: begin
                if (i_status.fsp_zero) begin
                    o_op    = OP_OINIT;
                    n_state = S_ORD;
                end else begin
                    o_op    = OP_PPOP;
                    n_state = S_PV;
                end
            end
            S_PV: begin
                if (i_status.v_labelled) begin
                    n_state = S_PPOP;
                end else begin
                    o_op    = OP_PSTART;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (i_status.i_end) begin
                    if (i_status.sp_zero) begin
                        n_state = S_PPOP;
                    end else begin
                        o_op    = OP_PSPOP_RD;
                        n_state = S_PSPOP;
                    end
                end else begin
                    o_op    = OP_PREAD;
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                o_op    = OP_PCHK;
                n_state = S_PRD;
            end
            S_PSPOP: begin
                o_op    = OP_PSPOP;
                n_state = S_PRD;
            end
            S_ORD: begin
                o_op    = OP_ORD;
                n_state = S_OEMIT;
            end
            S_OEMIT: begin
                o_op    = OP_OEMIT;
                n_state = i_status.last_i ? S_IDLE : S_ORD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> design/scc_dp.sv
`default_nettype none
module scc_dp
    import scc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_op               i_op,
    input  wire logic [NODE_W-1:0] i_row_index,
    input  wire logic [ROW_W-1:0]  i_row_bits,
    input  wire logic              i_last_row,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [NODE_W-1:0]      o_node_id,
    output logic [CNT_W-1:0]       o_component,
    output logic                   o_last_node
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = IW + CW;

    // Memories: forward rows, search stack, finish stack, labels.
    logic [MAX_NODES-1:0] r_fwd [MAX_NODES];
    logic [SW-1:0]        r_stk [MAX_NODES];
    logic [IW-1:0]        r_fin [MAX_NODES];
    logic [CW-1:0]        r_lab [MAX_NODES];

    logic [MAX_NODES-1:0] r_fwd_q;
    logic [SW-1:0]        r_stk_q;
    logic [IW-1:0]        r_fin_q;
    logic [CW-1:0]        r_lab_q;

    // Control registers of the searches.
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_s;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_sp;
    logic [CW-1:0]        r_fsp;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_v;
    logic [MAX_NODES-1:0] r_seen;
    logic [MAX_NODES-1:0] r_lbl;

    logic [CW-1:0]        sp_m1;
    logic [CW-1:0]        fsp_m1;
    logic                 row_ok;
    logic                 pchk_hit;
    logic [CW-1:0]        cnt_p1;

    assign sp_m1    = r_sp - 1'b1;
    assign fsp_m1   = r_fsp - 1'b1;
    assign cnt_p1   = r_cnt + 1'b1;
    assign row_ok   = ({1'b0, i_row_index} < CNT_W'(MAX_NODES));
    assign pchk_hit = r_fwd_q[r_v] && !r_lbl[r_i[IW-1:0]];

    // Status for the controller.
    always_comb begin
        o_status.k_end      = (r_k >= r_n);
        o_status.hit        = r_fwd_q[r_k[IW-1:0]] && !r_seen[r_k[IW-1:0]];
        o_status.sp_zero    = (r_sp == '0);
        o_status.fsp_zero   = (r_fsp == '0);
        o_status.s_end      = (r_s >= r_n);
        o_status.s_seen     = r_seen[r_s[IW-1:0]];
        o_status.i_end      = (r_i >= r_n);
        o_status.v_labelled = r_lbl[r_fin_q];
        o_status.last_i     = (r_i == r_n - 1'b1);
    end

    // Node count register, clamped to the supported range on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= CW'(MAX_NODES);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_n <= CW'(1);
            end else if (i_cfg_data > CNT_W'(MAX_NODES)) begin
                r_n <= CW'(MAX_NODES);
            end else begin
                r_n <= CW'(i_cfg_data);
            end
        end
    end

    // Forward row memory: written on a row transfer, read by both passes.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && row_ok) begin
            r_fwd[i_row_index[IW-1:0]] <= i_row_bits[MAX_NODES-1:0];
        end
        if (i_op == OP_FREAD) begin
            r_fwd_q <= r_fwd[r_v];
        end else if (i_op == OP_PREAD) begin
            r_fwd_q <= r_fwd[r_i[IW-1:0]];
        end
    end

    // Search stack memory, holding the entries below the current node.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_FPUSH) begin
            r_stk[r_sp[IW-1:0]] <= {r_k + 1'b1, r_v};
        end else if (i_op == OP_PCHK && pchk_hit) begin
            r_stk[r_sp[IW-1:0]] <= {CW'(0), r_i[IW-1:0]};
        end
        if ((i_op == OP_FFIN && r_sp != '0) || i_op == OP_PSPOP_RD) begin
            r_stk_q <= r_stk[sp_m1[IW-1:0]];
        end
    end

    // Finish order stack memory.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_FFIN) begin
            r_fin[r_fsp[IW-1:0]] <= r_v;
        end
        if (i_op == OP_PPOP) begin
            r_fin_q <= r_fin[fsp_m1[IW-1:0]];
        end
    end

    // Label memory; the labelled bits stand for its per-run clearing.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_PSTART) begin
            r_lab[r_fin_q] <= cnt_p1;
        end else if (i_op == OP_PCHK && pchk_hit) begin
            r_lab[r_i[IW-1:0]] <= r_cnt;
        end
        if (i_op == OP_ORD) begin
            r_lab_q <= r_lab[r_i[IW-1:0]];
        end
    end

    // Search counters, stack pointers and visit marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s    <= '0;
            r_k    <= '0;
            r_i    <= '0;
            r_sp   <= '0;
            r_fsp  <= '0;
            r_cnt  <= '0;
            r_v    <= '0;
            r_seen <= '0;
            r_lbl  <= '0;
        end else begin
            case (i_op)
                OP_LOAD: begin
                    if (i_last_row) begin
                        r_s    <= '0;
                        r_fsp  <= '0;
                        r_cnt  <= '0;
                        r_seen <= '0;
                        r_lbl  <= '0;
                    end
                end
                OP_SKIP: begin
                    r_s <= r_s + 1'b1;
                end
                OP_FSTART: begin
                    r_seen[r_s[IW-1:0]] <= 1'b1;
                    r_v  <= r_s[IW-1:0];
                    r_k  <= '0;
                    r_sp <= '0;
                    r_s  <= r_s + 1'b1;
                end
                OP_FSTEP: begin
                    r_k <= r_k + 1'b1;
                end
                OP_FPUSH: begin
                    r_seen[r_k[IW-1:0]] <= 1'b1;
                    r_v  <= r_k[IW-1:0];
                    r_k  <= '0;
                    r_sp <= r_sp + 1'b1;
                end
                OP_FFIN: begin
                    r_fsp <= r_fsp + 1'b1;
                    if (r_sp != '0) begin
                        r_sp <= sp_m1;
                    end
                end
                OP_FPOP: begin
                    r_v <= r_stk_q[IW-1:0];
                    r_k <= r_stk_q[IW +: CW];
                end
                OP_PPOP: begin
                    r_fsp <= fsp_m1;
                end
                OP_PSTART: begin
                    r_lbl[r_fin_q] <= 1'b1;
                    r_cnt <= cnt_p1;
                    r_v   <= r_fin_q;
                    r_i   <= '0;
                    r_sp  <= '0;
                end
                OP_PCHK: begin
                    if (pchk_hit) begin
                        r_lbl[r_i[IW-1:0]] <= 1'b1;
                        r_sp <= r_sp + 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                end
                OP_PSPOP_RD: begin
                    r_sp <= sp_m1;
                end
                OP_PSPOP: begin
                    r_v <= r_stk_q[IW-1:0];
                    r_i <= '0;
                end
                OP_OINIT: begin
                    r_i <= '0;
                end
                OP_OEMIT: begin
                    r_i <= r_i + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result registers: one transfer per node after the run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_op == OP_OEMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_OEMIT) begin
            o_node_id   <= NODE_W'(r_i);
            o_component <= r_lbl[r_i[IW-1:0]] ? CNT_W'(r_lab_q) : '0;
            o_last_node <= o_status.last_i;
        end
    end

endmodule
`default_nettype wire
